### design/deque_with_min_max_sum_defines.svh
// ----------------------------------------------------------------------------
// Deque assertion macros
// Shared concurrent assertion forms for the deque block.
// ----------------------------------------------------------------------------
`ifndef DEQUE_WITH_MIN_MAX_SUM_DEFINES_SVH
`define DEQUE_WITH_MIN_MAX_SUM_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DQ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/dqmms_pkg.sv
// ----------------------------------------------------------------------------
// Deque package
// Sizes, action codes, sequencer states and ring arithmetic for the deque.
// ----------------------------------------------------------------------------
`default_nettype none

package dqmms_pkg;

	localparam int DEPTH       = 64;
	localparam int PTR_W       = $clog2(DEPTH);
	localparam int CNT_W       = $clog2(DEPTH + 1);
	localparam int DATA_W      = 32;
	localparam int TOTAL_W     = 38;
	localparam int COUNT_W     = 7;
	localparam int ACT_W       = 3;
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_FIELD_W = 4 * DATA_W + COUNT_W + TOTAL_W + 1;
	localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

	typedef enum logic [ACT_W-1:0] {
		ACT_PUSH_BACK  = 3'd0,
		ACT_PUSH_FRONT = 3'd1,
		ACT_POP_BACK   = 3'd2,
		ACT_POP_FRONT  = 3'd3,
		ACT_NONE       = 3'd4
	} dq_action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} dq_state_t;

	function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] ptr,
		input logic [PTR_W-1:0] off);
		logic [PTR_W:0] sum;
		begin
			sum = {1'b0, ptr} + {1'b0, off};
			if (sum >= (PTR_W + 1)'(DEPTH)) begin
				sum = sum - (PTR_W + 1)'(DEPTH);
			end
			return sum[PTR_W-1:0];
		end
	endfunction

endpackage

`default_nettype wire

### design/dqmms_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dqmms_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

### design/deque_with_min_max_sum.sv
// ----------------------------------------------------------------------------
// Deque with minimum, maximum and sum
// Bounded double-ended queue of signed 32-bit values in a ring buffer.
// ----------------------------------------------------------------------------
// The input channel carries one item per action: s_axis_tuser holds the
// action code and s_axis_tdata the value to push. The output channel returns
// one result item per input item with front, back, count, minimum, maximum,
// exact sum and a flag for a push refused on a full queue.
// An item goes from acceptance to its result in these steps: the action is
// applied, one RAM read per value stored after the action gives front,
// back, minimum and maximum, the last read data is taken in, and the output
// register is loaded. An item that leaves the queue empty skips the reads.
// s_axis_tready is high only in the idle state, entered after each result
// load, so a new item is taken only once the last one has loaded its
// result, with one item in flight.
// A finished result waits in the output register, so a new item may be taken
// while the receiver stalls; the next result waits until the old one is
// taken. Reset empties the queue and clears the sum, minimum and maximum.
// ----------------------------------------------------------------------------
`default_nettype none

`include "deque_with_min_max_sum_defines.svh"

module deque_with_min_max_sum (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 s_axis_tvalid,
	output logic                                      s_axis_tready,
	// value [31:0]
	input  wire logic [dqmms_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	// action [2:0]
	input  wire logic [dqmms_pkg::ACT_W-1:0]          s_axis_tuser,
	output logic                                      m_axis_tvalid,
	input  wire logic                                 m_axis_tready,
	// front_value [31:0], back_value [63:32], count [70:64], minimum [102:71],
	// maximum [134:103], total [172:135], dropped [173], zero fill above
	output logic [dqmms_pkg::OUT_TDATA_W-1:0]         m_axis_tdata
);

	import dqmms_pkg::*;

	dq_state_t                  state_q, state_d;
	dq_action_t                 action_q;
	logic        [DATA_W-1:0]   value_q;
	logic        [PTR_W-1:0]    head_q;
	logic        [CNT_W-1:0]    cnt_q;
	logic        [CNT_W-1:0]    cnt_upd;
	logic        [TOTAL_W-1:0]  total_q;
	logic signed [DATA_W-1:0]   min_q, max_q;
	logic        [DATA_W-1:0]   front_q, back_q;
	logic                       dropped_q;
	logic        [PTR_W-1:0]    rd_q;
	logic                       rd_vld_q;
	logic                       first_q;
	logic                       out_vld_q;
	logic        [OUT_TDATA_W-1:0] out_data_q;
	logic                       is_push, is_pop, full, empty, do_push, do_pop;
	logic                       out_load;
	logic        [PTR_W-1:0]    head_dec;
	logic                       ram_we;
	logic        [PTR_W-1:0]    ram_waddr, ram_raddr;
	logic        [DATA_W-1:0]   ram_rdata;
	logic        [DATA_W-1:0]   gone;

	assign is_push  = (action_q == ACT_PUSH_BACK) || (action_q == ACT_PUSH_FRONT);
	assign is_pop   = (action_q == ACT_POP_BACK) || (action_q == ACT_POP_FRONT);
	assign full     = (cnt_q == CNT_W'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign do_push  = is_push && !full;
	assign do_pop   = is_pop && !empty;
	assign head_dec = (head_q == '0) ? PTR_W'(DEPTH - 1) : head_q - PTR_W'(1);
	assign gone     = (action_q == ACT_POP_FRONT) ? front_q : back_q;
	assign out_load = (state_q == ST_FINISH) && (!out_vld_q || m_axis_tready);

	always_comb begin
		cnt_upd = cnt_q;
		if (do_push) begin
			cnt_upd = cnt_q + CNT_W'(1);
		end else if (do_pop) begin
			cnt_upd = cnt_q - CNT_W'(1);
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				state_d = (cnt_upd == '0) ? ST_FINISH : ST_SCAN;
			end
			ST_SCAN: begin
				if ((CNT_W'(rd_q) + CNT_W'(1)) == cnt_q) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		s_axis_tready = (state_q == ST_IDLE);
		ram_we        = (state_q == ST_UPDATE) && do_push;
		ram_waddr     = (action_q == ACT_PUSH_FRONT) ? head_dec :
			ring_add(head_q, cnt_q[PTR_W-1:0]);
		ram_raddr     = ring_add(head_q, rd_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			action_q   <= ACT_NONE;
			value_q    <= '0;
			head_q     <= '0;
			cnt_q      <= '0;
			total_q    <= '0;
			min_q      <= '0;
			max_q      <= '0;
			front_q    <= '0;
			back_q     <= '0;
			dropped_q  <= 1'b0;
			rd_q       <= '0;
			rd_vld_q   <= 1'b0;
			first_q    <= 1'b0;
			out_vld_q  <= 1'b0;
			out_data_q <= '0;
		end else begin
			rd_vld_q <= (state_q == ST_SCAN);
			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						action_q <= dq_action_t'(s_axis_tuser);
						value_q  <= s_axis_tdata[DATA_W-1:0];
					end
				end
				ST_UPDATE: begin
					dropped_q <= is_push && full;
					cnt_q     <= cnt_upd;
					rd_q      <= '0;
					first_q   <= 1'b1;
					if (cnt_upd == '0) begin
						head_q  <= '0;
						total_q <= '0;
						min_q   <= '0;
						max_q   <= '0;
						front_q <= '0;
						back_q  <= '0;
					end else if (do_push) begin
						total_q <= total_q +
							{{(TOTAL_W - DATA_W){value_q[DATA_W-1]}}, value_q};
						if (action_q == ACT_PUSH_FRONT) begin
							head_q <= head_dec;
						end
					end else if (do_pop) begin
						total_q <= total_q -
							{{(TOTAL_W - DATA_W){gone[DATA_W-1]}}, gone};
						if (action_q == ACT_POP_FRONT) begin
							head_q <= ring_add(head_q, PTR_W'(1));
						end
					end
				end
				ST_SCAN: begin
					rd_q <= rd_q + PTR_W'(1);
				end
				default: begin
				end
			endcase
			if (rd_vld_q) begin
				back_q <= ram_rdata;
				if (first_q) begin
					first_q <= 1'b0;
					front_q <= ram_rdata;
					min_q   <= $signed(ram_rdata);
					max_q   <= $signed(ram_rdata);
				end else begin
					if ($signed(ram_rdata) < min_q) begin
						min_q <= $signed(ram_rdata);
					end
					if ($signed(ram_rdata) > max_q) begin
						max_q <= $signed(ram_rdata);
					end
				end
			end
			if (out_load) begin
				out_vld_q  <= 1'b1;
				out_data_q <= OUT_TDATA_W'({dropped_q, total_q, max_q, min_q,
					COUNT_W'(cnt_q), back_q, front_q});
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	dqmms_ram #(
		.WIDTH(DATA_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (value_q),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;

	`DQ_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(DEPTH), "Count exceeds the depth.")
	`DQ_ASSERT_NOW(a_empty_zero, (state_q == ST_FINISH) && (cnt_q == '0),
		(min_q == '0) && (max_q == '0) && (total_q == '0), "Empty queue with nonzero status.")
	`DQ_ASSERT_NOW(a_min_max, (state_q == ST_FINISH) && (cnt_q != '0),
		min_q <= max_q, "Minimum above maximum.")
	`DQ_ASSERT_NEXT(a_full_drop, (state_q == ST_UPDATE) && is_push && full,
		(cnt_q == $past(cnt_q)) && $stable(total_q) && dropped_q,
		"Push on a full queue changed the state.")

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deque with minimum, maximum and sum testbench
// A directed table covers the empty queue, extreme values and unused action
// codes. Random episodes then fill the queue past full and drain it, mix
// pushes and pops, and send noise codes. Every result item is checked field
// by field against a queue-based predictor or, for typed table rows, the
// status given in the table, with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;
	import dqmms_pkg::*;

	localparam int RANDOM_ITEMS = 1000;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int REPORT_CAP   = 200;
	localparam int PLAN_N       = 21;

	localparam logic [ACT_W-1:0] ACT_SPARE5 = 3'd5;
	localparam logic [ACT_W-1:0] ACT_SPARE6 = 3'd6;
	localparam logic [ACT_W-1:0] ACT_SPARE7 = 3'd7;

	typedef struct packed {
		logic                dropped;
		logic [TOTAL_W-1:0]  total;
		logic [DATA_W-1:0]   max_v;
		logic [DATA_W-1:0]   min_v;
		logic [COUNT_W-1:0]  count;
		logic [DATA_W-1:0]   back_v;
		logic [DATA_W-1:0]   front_v;
	} deque_status_t;

	typedef struct packed {
		logic [ACT_W-1:0]  act;
		logic [DATA_W-1:0] val;
		logic              typed;
		deque_status_t     want;
	} plan_row_t;

	typedef enum {EP_MIX, EP_FILL_DRAIN, EP_NOISE} episode_t;
	typedef enum {VM_RANDOM, VM_SMALL, VM_EXTREME, VM_ALL_MAX, VM_ALL_MIN} value_mode_t;
	typedef enum {RX_FREE, RX_JITTER, RX_LONG} rx_mode_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic [ACT_W-1:0]       s_axis_tuser = ACT_NONE;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	logic signed [DATA_W-1:0]  held[$];
	logic signed [TOTAL_W-1:0] held_sum = '0;
	deque_status_t             status_due[$];

	int       errors = 0;
	int       cycles = 0;
	int       items_done = 0;
	int       burst_left = 0;
	int       gap_max = 0;
	int       rx_hold = 0;
	rx_mode_t rx_mode = RX_FREE;

	plan_row_t plan [PLAN_N] = '{
		'{ACT_POP_BACK,   32'h0000_0000, 1'b1, '0},
		'{ACT_POP_FRONT,  32'hFFFF_FFFF, 1'b1, '0},
		'{ACT_NONE,       32'h5A5A_5A5A, 1'b1, '0},
		'{ACT_SPARE5,     32'h1234_5678, 1'b1, '0},
		'{ACT_PUSH_BACK,  32'h7FFF_FFFF, 1'b1, '{dropped: 1'b0, total: 38'h00_7FFF_FFFF,
			max_v: 32'h7FFF_FFFF, min_v: 32'h7FFF_FFFF, count: 7'd1,
			back_v: 32'h7FFF_FFFF, front_v: 32'h7FFF_FFFF}},
		'{ACT_PUSH_FRONT, 32'h8000_0000, 1'b1, '{dropped: 1'b0, total: 38'h3F_FFFF_FFFF,
			max_v: 32'h7FFF_FFFF, min_v: 32'h8000_0000, count: 7'd2,
			back_v: 32'h7FFF_FFFF, front_v: 32'h8000_0000}},
		'{ACT_SPARE6,     32'hFFFF_FFFF, 1'b0, '0},
		'{ACT_SPARE7,     32'h0000_0000, 1'b0, '0},
		'{ACT_PUSH_BACK,  32'h0000_0000, 1'b0, '0},
		'{ACT_PUSH_FRONT, 32'hFFFF_FFFF, 1'b0, '0},
		'{ACT_POP_FRONT,  32'hA5A5_A5A5, 1'b0, '0},
		'{ACT_POP_FRONT,  32'h0000_0000, 1'b0, '0},
		'{ACT_POP_BACK,   32'h0000_0000, 1'b0, '0},
		'{ACT_POP_BACK,   32'hFFFF_FFFF, 1'b1, '0},
		'{ACT_PUSH_FRONT, 32'h0000_0001, 1'b0, '0},
		'{ACT_PUSH_BACK,  32'hFFFF_FFFF, 1'b0, '0},
		'{ACT_PUSH_BACK,  32'h0000_0001, 1'b0, '0},
		'{ACT_POP_BACK,   32'h0000_0000, 1'b0, '0},
		'{ACT_POP_FRONT,  32'h0000_0000, 1'b0, '0},
		'{ACT_POP_FRONT,  32'h0000_0000, 1'b1, '0},
		'{ACT_POP_FRONT,  32'h0000_0000, 1'b1, '0}
	};

	deque_with_min_max_sum DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic deque_status_t step_deque(input logic [ACT_W-1:0] act,
		input logic [DATA_W-1:0] val);
		deque_status_t            st;
		logic signed [DATA_W-1:0] gone;
		logic signed [DATA_W-1:0] lo;
		logic signed [DATA_W-1:0] hi;
		st = '0;
		case (act)
			ACT_PUSH_BACK, ACT_PUSH_FRONT: begin
				if (held.size() >= DEPTH) begin
					st.dropped = 1'b1;
				end else begin
					if (act == ACT_PUSH_BACK) begin
						held.insert(held.size(), val);
					end else begin
						held.insert(0, val);
					end
					held_sum = held_sum + {{(TOTAL_W - DATA_W){val[DATA_W-1]}}, val};
				end
			end
			ACT_POP_BACK, ACT_POP_FRONT: begin
				if (held.size() > 0) begin
					if (act == ACT_POP_BACK) begin
						gone = held[held.size() - 1];
						held.delete(held.size() - 1);
					end else begin
						gone = held[0];
						held.delete(0);
					end
					held_sum = held_sum - {{(TOTAL_W - DATA_W){gone[DATA_W-1]}}, gone};
				end
			end
			default: begin
			end
		endcase
		if (held.size() > 0) begin
			lo = held[0];
			hi = held[0];
			foreach (held[i]) begin
				if (held[i] < lo) begin
					lo = held[i];
				end
				if (held[i] > hi) begin
					hi = held[i];
				end
			end
			st.front_v = held[0];
			st.back_v  = held[$];
			st.min_v   = lo;
			st.max_v   = hi;
			st.total   = held_sum;
		end
		st.count = COUNT_W'(held.size());
		return st;
	endfunction

	function automatic logic [DATA_W-1:0] pick_value(input value_mode_t m);
		case (m)
			VM_SMALL:   return DATA_W'($urandom_range(0, 16)) - 32'd8;
			VM_EXTREME: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			VM_ALL_MAX: return 32'h7FFF_FFFF;
			VM_ALL_MIN: return 32'h8000_0000;
			default:    return $urandom();
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		if (errors < REPORT_CAP) begin
			$display("%0t ns: %s mismatch, got %h expected %h", $time, what, got, want);
		end
		errors++;
	endtask

	task automatic send_item(input logic [ACT_W-1:0] act, input logic [DATA_W-1:0] val,
		input logic use_want, input deque_status_t want);
		int            gap;
		deque_status_t pred;
		if (burst_left == 0) begin
			gap = $urandom_range(0, gap_max);
			if (gap > 0) begin
				@(negedge clk);
				s_axis_tvalid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= val;
		s_axis_tuser  <= act;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		pred = step_deque(act, val);
		status_due.insert(status_due.size(), use_want ? want : pred);
		burst_left--;
		if (act <= ACT_POP_FRONT) begin
			items_done++;
		end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (status_due.size() != 0) @(posedge clk);
	endtask

	always @(negedge clk) begin
		if (rx_hold > 0) begin
			rx_hold <= rx_hold - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
			case (rx_mode)
				RX_JITTER: begin
					if ($urandom_range(0, 3) == 0) rx_hold <= $urandom_range(1, 3);
				end
				RX_LONG: begin
					if ($urandom_range(0, 7) == 0) rx_hold <= $urandom_range(4, 20);
				end
				default: begin
				end
			endcase
		end
		if (cycles % 700 == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(0, 2));
		end
	end

	always @(posedge clk) begin : check_results
		deque_status_t got;
		deque_status_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[OUT_FIELD_W-1:0];
			if (status_due.size() == 0) begin
				report_mismatch("unexpected result, front", got.front_v, '0);
			end else begin
				want = status_due[0];
				status_due.delete(0);
				if (got.front_v !== want.front_v)
					report_mismatch("front_value", got.front_v, want.front_v);
				if (got.back_v !== want.back_v)
					report_mismatch("back_value", got.back_v, want.back_v);
				if (got.count !== want.count)
					report_mismatch("count", got.count, want.count);
				if (got.min_v !== want.min_v)
					report_mismatch("minimum", got.min_v, want.min_v);
				if (got.max_v !== want.max_v)
					report_mismatch("maximum", got.max_v, want.max_v);
				if (got.total !== want.total)
					report_mismatch("total", got.total, want.total);
				if (got.dropped !== want.dropped)
					report_mismatch("dropped", got.dropped, want.dropped);
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("deque_with_min_max_sum test failed");
			$finish;
		end
	end

	initial begin : stimulus
		episode_t         ep;
		value_mode_t      vm;
		logic [ACT_W-1:0] act;
		int               n;
		int               episodes;
		episodes = 0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		gap_max = 3;
		foreach (plan[i]) begin
			send_item(plan[i].act, plan[i].val, plan[i].typed, plan[i].want);
		end
		wait_drained();

		items_done = 0;
		while (items_done < RANDOM_ITEMS) begin
			ep      = episode_t'($urandom_range(0, 99) < 30 ? EP_FILL_DRAIN :
				($urandom_range(0, 99) < 80 ? EP_MIX : EP_NOISE));
			vm      = value_mode_t'($urandom_range(0, 4));
			gap_max = ($urandom_range(0, 2) == 0) ? 0 : (($urandom_range(0, 1) == 0) ? 3 : 12);
			case (ep)
				EP_FILL_DRAIN: begin
					while (held.size() < DEPTH) begin
						act = $urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
						send_item(act, pick_value(vm), 1'b0, '0);
					end
					repeat ($urandom_range(1, 3)) begin
						act = $urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
						send_item(act, pick_value(VM_RANDOM), 1'b0, '0);
					end
					while (held.size() > 0) begin
						act = $urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_BACK;
						send_item(act, $urandom(), 1'b0, '0);
					end
					send_item($urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_BACK,
						$urandom(), 1'b0, '0);
				end
				EP_MIX: begin
					n = $urandom_range(20, 60);
					repeat (n) begin
						if ($urandom_range(0, 99) >= 95) begin
							act = ACT_W'($urandom_range(ACT_NONE, ACT_SPARE7));
						end else if ($urandom_range(0, 99) < (held.size() > 48 ? 35 : 55)) begin
							act = $urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
						end else begin
							act = $urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_BACK;
						end
						send_item(act, pick_value(vm), 1'b0, '0);
					end
				end
				default: begin
					n = $urandom_range(5, 15);
					repeat (n) begin
						send_item(ACT_W'($urandom_range(0, 7)), $urandom(), 1'b0, '0);
					end
				end
			endcase
			episodes++;
			if (episodes % 4 == 0) begin
				wait_drained();
			end
		end

		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (status_due.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
		if (errors == 0) begin
			$display("deque_with_min_max_sum test passed");
		end else begin
			$display("deque_with_min_max_sum test failed");
		end
		$finish;
	end

endmodule

### filelist.f
+incdir+design
design/dqmms_pkg.sv
design/dqmms_ram.sv
design/deque_with_min_max_sum.sv
tb/sv/tb_top.sv
